[src/cbe_pkg.sv]
`default_nettype none
package cbe_pkg;

  // Coordinate and parameter formats.
  localparam int CW    = 21;           // control point coordinate, signed Q12.8
  localparam int CFGW  = 3 * CW;       // packed x, y, z control point register
  localparam int SFW   = 23;           // speed floor register
  localparam int TFB   = 16;           // fraction bits of the curve parameter
  localparam int TW    = TFB + 1;      // curve parameter, 1.0 included
  localparam int GB    = 12;           // guard fraction bits in the Horner terms
  localparam int HW    = 40;           // Horner accumulator
  localparam int PW    = HW + TW + 1;  // Horner product with the parameter
  localparam int TANW  = 24;           // first derivative
  localparam int ACCW  = 26;           // second derivative
  localparam int CURW  = 24;           // curvature, unsigned Q8.16

  // Output clamp limits.
  localparam logic signed [HW-1:0] POS_MAX = HW'((1 << (CW - 1)) - 1);
  localparam logic signed [HW-1:0] POS_MIN = -HW'(1 << (CW - 1));
  localparam logic signed [HW-1:0] TAN_MAX = HW'(3 << CW);
  localparam logic signed [HW-1:0] TAN_MIN = -HW'(3 << CW);
  localparam logic signed [HW-1:0] ACC_MAX = HW'(3 << (CW + 2));
  localparam logic signed [HW-1:0] ACC_MIN = -HW'(3 << (CW + 2));

  // Curvature datapath widths.
  localparam int XPW   = TANW + ACCW;  // tangent times acceleration
  localparam int TSQW  = 2 * TANW;     // tangent component squared
  localparam int CRW   = 49;           // cross product magnitude
  localparam int LOW   = 25;           // low half of the cross magnitude
  localparam int HIW   = CRW - LOW;    // high half of the cross magnitude
  localparam int CSQW  = 2 * CRW;      // one cross component squared
  localparam int ROOT_BITS = 51;       // square root result bits
  localparam int RADW  = 2 * ROOT_BITS;// square root radicand
  localparam int SW    = 26;           // speed
  localparam int DENW  = 3 * SW;       // speed cubed
  localparam int QUO_BITS = CURW;      // quotient bits of the curvature divide
  localparam int REMW  = ROOT_BITS + QUO_BITS;
  localparam int CMPW  = DENW + QUO_BITS;

  // Pipeline depths.
  localparam int POLY_LAT  = 8;
  localparam int CROSS_LAT = 5;
  localparam int CUBE_LAT  = 3;
  localparam int DIV_LAT   = QUO_BITS + 1;
  localparam int CURV_LAT  = CROSS_LAT + ROOT_BITS + CUBE_LAT + DIV_LAT;
  localparam int TOTAL_LAT = POLY_LAT + CURV_LAT;

  // Stream widths.
  localparam int IN_DW  = ((TW + 7) / 8) * 8;
  localparam int PAYW   = 3 * (CW + TANW + ACCW);
  localparam int OUT_DW = ((PAYW + CURW + 7) / 8) * 8;
  localparam int PADW   = OUT_DW - PAYW - CURW;

  // Configuration register indexes.
  localparam int IDXW = 3;
  localparam logic [IDXW-1:0] REG_START_POINT   = 3'd0;
  localparam logic [IDXW-1:0] REG_FIRST_HANDLE  = 3'd1;
  localparam logic [IDXW-1:0] REG_SECOND_HANDLE = 3'd2;
  localparam logic [IDXW-1:0] REG_END_POINT     = 3'd3;
  localparam logic [IDXW-1:0] REG_SPEED_FLOOR   = 3'd4;

  typedef logic signed [CW-1:0]   pos_t;
  typedef logic signed [TANW-1:0] tan_t;
  typedef logic signed [ACCW-1:0] acc_t;

  // Point and derivatives of one sample, x in the lowest bits of each group.
  typedef struct packed {
    acc_t [2:0] acc;
    tan_t [2:0] tan;
    pos_t [2:0] pos;
  } pay_t;

  // One finished result.
  typedef struct packed {
    logic            slow;
    logic [CURW-1:0] curv;
    pay_t            pay;
  } res_t;

endpackage
`default_nettype wire

[src/cbe_poly.sv]
`default_nettype none
module cbe_poly (
  input  logic                     clk,
  input  logic                     en,
  input  logic [cbe_pkg::CFGW-1:0] start_point,
  input  logic [cbe_pkg::CFGW-1:0] first_handle,
  input  logic [cbe_pkg::CFGW-1:0] second_handle,
  input  logic [cbe_pkg::CFGW-1:0] end_point,
  input  logic [cbe_pkg::TW-1:0]   param_t,
  output cbe_pkg::pay_t            pay
);
  import cbe_pkg::*;

  typedef struct packed {
    logic signed [HW-1:0] a_pos;
    logic signed [HW-1:0] a_tan;
    logic signed [HW-1:0] a_acc;
    logic signed [HW-1:0] b1;
    logic signed [HW-1:0] b2;
    logic signed [HW-1:0] c1;
    logic signed [HW-1:0] d1;
  } coef_t;

  localparam logic [TW-1:0] T_ONE = TW'(1 << TFB);

  function automatic logic signed [HW-1:0] coord(input logic [CFGW-1:0] r, input int ax);
    logic [CW-1:0] f;
    f = r[ax*CW +: CW];
    return {{(HW - CW){f[CW-1]}}, f};
  endfunction

  // Drop the parameter fraction bits, rounding half up.
  function automatic logic signed [HW-1:0] rnd_t(input logic signed [PW-1:0] m);
    logic signed [PW-1:0] r;
    r = m + (PW'(1) <<< (TFB - 1));
    return HW'(r >>> TFB);
  endfunction

  // Drop the guard bits, rounding half up.
  function automatic logic signed [HW-1:0] rnd_g(input logic signed [HW-1:0] h);
    logic signed [HW-1:0] r;
    r = h + (HW'(1) <<< (GB - 1));
    return r >>> GB;
  endfunction

  function automatic logic signed [HW-1:0] clamp(input logic signed [HW-1:0] v,
                                                 input logic signed [HW-1:0] lo,
                                                 input logic signed [HW-1:0] hi);
    logic signed [HW-1:0] r;
    r = v;
    if (v < lo) r = lo;
    if (v > hi) r = hi;
    return r;
  endfunction

  coef_t coef_next [3];
  coef_t coef      [3];

  logic [TW-1:0] t1, t2, t3, t4, t5;
  logic signed [PW-1:0] mp2 [3], mt2 [3], ma2 [3];
  logic signed [HW-1:0] hp3 [3], ht3 [3], ha3 [3];
  logic signed [PW-1:0] mp4 [3], mt4 [3];
  logic signed [HW-1:0] hp5 [3], ht5 [3];
  logic signed [PW-1:0] mp6 [3];
  logic signed [HW-1:0] hp7 [3];
  acc_t acc4 [3], acc5 [3], acc6 [3], acc7 [3];
  tan_t tan6 [3], tan7 [3];

  logic signed [TW:0] ts1, ts3, ts5;
  assign ts1 = {1'b0, t1};
  assign ts3 = {1'b0, t3};
  assign ts5 = {1'b0, t5};

  // Power basis coefficients with guard bits, one set per axis.
  always_comb begin
    logic signed [HW-1:0] p0, p1, p2, p3, a, a3, b, c, e, f;
    for (int ax = 0; ax < 3; ax++) begin
      p0 = coord(start_point, ax);
      p1 = coord(first_handle, ax);
      p2 = coord(second_handle, ax);
      p3 = coord(end_point, ax);
      a  = p3 - ((p2 <<< 1) + p2) + ((p1 <<< 1) + p1) - p0;
      e  = p0 - (p1 <<< 1) + p2;
      b  = (e <<< 1) + e;
      f  = p1 - p0;
      c  = (f <<< 1) + f;
      a3 = (a <<< 1) + a;
      coef_next[ax].a_pos = a <<< GB;
      coef_next[ax].a_tan = a3 <<< GB;
      coef_next[ax].a_acc = a3 <<< (GB + 1);
      coef_next[ax].b1    = b <<< GB;
      coef_next[ax].b2    = b <<< (GB + 1);
      coef_next[ax].c1    = c <<< GB;
      coef_next[ax].d1    = p0 <<< GB;
    end
  end

  // The coefficients follow the control point registers.
  always_ff @(posedge clk) begin
    for (int ax = 0; ax < 3; ax++) begin
      coef[ax] <= coef_next[ax];
    end
  end

  // Horner stages: clamp t to 1.0, multiply by t, then round and add the next coefficient.
  always_ff @(posedge clk) begin
    if (en) begin
      t1 <= (param_t > T_ONE) ? T_ONE : param_t;
      t2 <= t1;
      t3 <= t2;
      t4 <= t3;
      t5 <= t4;
      for (int ax = 0; ax < 3; ax++) begin
        mp2[ax]  <= coef[ax].a_pos * ts1;
        mt2[ax]  <= coef[ax].a_tan * ts1;
        ma2[ax]  <= coef[ax].a_acc * ts1;

        hp3[ax]  <= rnd_t(mp2[ax]) + coef[ax].b1;
        ht3[ax]  <= rnd_t(mt2[ax]) + coef[ax].b2;
        ha3[ax]  <= rnd_t(ma2[ax]) + coef[ax].b2;

        mp4[ax]  <= hp3[ax] * ts3;
        mt4[ax]  <= ht3[ax] * ts3;
        acc4[ax] <= ACCW'(clamp(rnd_g(ha3[ax]), ACC_MIN, ACC_MAX));

        hp5[ax]  <= rnd_t(mp4[ax]) + coef[ax].c1;
        ht5[ax]  <= rnd_t(mt4[ax]) + coef[ax].c1;
        acc5[ax] <= acc4[ax];

        mp6[ax]  <= hp5[ax] * ts5;
        tan6[ax] <= TANW'(clamp(rnd_g(ht5[ax]), TAN_MIN, TAN_MAX));
        acc6[ax] <= acc5[ax];

        hp7[ax]  <= rnd_t(mp6[ax]) + coef[ax].d1;
        tan7[ax] <= tan6[ax];
        acc7[ax] <= acc6[ax];

        pay.pos[ax] <= CW'(clamp(rnd_g(hp7[ax]), POS_MIN, POS_MAX));
        pay.tan[ax] <= tan7[ax];
        pay.acc[ax] <= acc7[ax];
      end
    end
  end

endmodule
`default_nettype wire

[src/cbe_isqrt.sv]
`default_nettype none
module cbe_isqrt (
  input  logic                          clk,
  input  logic                          en,
  input  logic [cbe_pkg::RADW-1:0]      radicand,
  output logic [cbe_pkg::ROOT_BITS-1:0] root
);
  import cbe_pkg::*;

  logic [RADW-1:0]      rm [ROOT_BITS];
  logic [ROOT_BITS-1:0] rt [ROOT_BITS];

  // One root bit per stage, highest first, on a running remainder.
  for (genvar j = 0; j < ROOT_BITS; j++) begin : g_bit
    localparam int B = ROOT_BITS - 1 - j;
    logic [RADW-1:0]      rm_in;
    logic [ROOT_BITS-1:0] rt_in;
    logic [RADW-1:0]      trial;
    logic                 fits;

    if (j == 0) begin : g_first
      assign rm_in = radicand;
      assign rt_in = '0;
    end else begin : g_rest
      assign rm_in = rm[j-1];
      assign rt_in = rt[j-1];
    end

    assign trial = (RADW'(rt_in) << (B + 1)) | (RADW'(1) << (2 * B));
    assign fits  = (rm_in >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        rm[j] <= fits ? rm_in - trial : rm_in;
        rt[j] <= fits ? (rt_in | (ROOT_BITS'(1) << B)) : rt_in;
      end
    end
  end

  assign root = rt[ROOT_BITS-1];

endmodule
`default_nettype wire

[src/cbe_div.sv]
`default_nettype none
module cbe_div (
  input  logic                          clk,
  input  logic                          en,
  input  logic [cbe_pkg::ROOT_BITS-1:0] cross_mag,
  input  logic [cbe_pkg::DENW-1:0]      speed_cube,
  input  logic                          slow_in,
  output logic [cbe_pkg::CURW-1:0]      curvature,
  output logic                          slow_flag
);
  import cbe_pkg::*;

  logic [REMW-1:0]     rem  [QUO_BITS+1];
  logic [DENW-1:0]     den  [QUO_BITS+1];
  logic [QUO_BITS-1:0] quo  [QUO_BITS+1];
  logic                sat  [QUO_BITS+1];
  logic                slow [QUO_BITS+1];

  // A quotient of one or more saturates; otherwise the numerator is scaled by 2^24.
  always_ff @(posedge clk) begin
    if (en) begin
      sat[0]  <= (DENW'(cross_mag) >= speed_cube);
      rem[0]  <= REMW'(cross_mag) << QUO_BITS;
      den[0]  <= speed_cube;
      quo[0]  <= '0;
      slow[0] <= slow_in;
    end
  end

  // Restoring division, one quotient bit per stage.
  for (genvar j = 0; j < QUO_BITS; j++) begin : g_step
    localparam int K = QUO_BITS - 1 - j;
    logic [CMPW-1:0] dsh;
    logic            fits;

    assign dsh  = CMPW'(den[j]) << K;
    assign fits = (CMPW'(rem[j]) >= dsh);

    always_ff @(posedge clk) begin
      if (en) begin
        rem[j+1]  <= fits ? REMW'(CMPW'(rem[j]) - dsh) : rem[j];
        quo[j+1]  <= fits ? (quo[j] | (QUO_BITS'(1) << K)) : quo[j];
        den[j+1]  <= den[j];
        sat[j+1]  <= sat[j];
        slow[j+1] <= slow[j];
      end
    end
  end

  // A slow curve reports zero curvature.
  always_comb begin
    priority if (slow[QUO_BITS]) begin
      curvature = '0;
    end else if (sat[QUO_BITS]) begin
      curvature = '1;
    end else begin
      curvature = quo[QUO_BITS];
    end
  end

  assign slow_flag = slow[QUO_BITS];

endmodule
`default_nettype wire

[src/cbe_curv.sv]
`default_nettype none
module cbe_curv (
  input  logic                     clk,
  input  logic                     en,
  input  logic [cbe_pkg::SFW-1:0]  speed_floor,
  input  cbe_pkg::pay_t            pay,
  output logic [cbe_pkg::CURW-1:0] curvature,
  output logic                     slow_flag
);
  import cbe_pkg::*;

  localparam int SSQW = TSQW;

  logic signed [TSQW-1:0] tsq1 [3];
  logic signed [XPW-1:0]  xp1  [6];
  logic [SSQW-1:0]        ssq2, ssq3, ssq4, ssq5;
  logic [CRW-1:0]         crab2 [3];
  logic [CRW-1:0]         crab_next [3];
  logic [2*HIW-1:0]       hh3 [3];
  logic [HIW+LOW-1:0]     hl3 [3];
  logic [2*LOW-1:0]       ll3 [3];
  logic [CSQW-1:0]        csq4 [3];
  logic [RADW-1:0]        csq5;
  logic [ROOT_BITS-1:0]   m_root, s_root;
  logic [SW-1:0]          s_val;
  logic [2*SW-1:0]        s2_1, phi2, plo2;
  logic [SW-1:0]          s1;
  logic [ROOT_BITS-1:0]   m1, m2, m3;
  logic                   slow1, slow2, slow3;
  logic [DENW-1:0]        den3;

  // Cross product components and their magnitudes.
  always_comb begin
    logic signed [XPW:0] cr;
    logic [XPW:0]        crm;
    for (int i = 0; i < 3; i++) begin
      cr  = (XPW + 1)'(xp1[2*i]) - (XPW + 1)'(xp1[2*i+1]);
      crm = cr[XPW] ? $unsigned(-cr) : $unsigned(cr);
      crab_next[i] = crm[CRW-1:0];
    end
  end

  // Squared speed and squared cross magnitude, cut into partial products.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        tsq1[i] <= $signed(pay.tan[i]) * $signed(pay.tan[i]);
      end
      xp1[0] <= $signed(pay.tan[1]) * $signed(pay.acc[2]);
      xp1[1] <= $signed(pay.tan[2]) * $signed(pay.acc[1]);
      xp1[2] <= $signed(pay.tan[2]) * $signed(pay.acc[0]);
      xp1[3] <= $signed(pay.tan[0]) * $signed(pay.acc[2]);
      xp1[4] <= $signed(pay.tan[0]) * $signed(pay.acc[1]);
      xp1[5] <= $signed(pay.tan[1]) * $signed(pay.acc[0]);

      ssq2 <= SSQW'(tsq1[0] + tsq1[1] + tsq1[2]);
      for (int i = 0; i < 3; i++) begin
        crab2[i] <= crab_next[i];
      end

      ssq3 <= ssq2;
      for (int i = 0; i < 3; i++) begin
        hh3[i] <= crab2[i][CRW-1:LOW] * crab2[i][CRW-1:LOW];
        hl3[i] <= crab2[i][CRW-1:LOW] * crab2[i][LOW-1:0];
        ll3[i] <= crab2[i][LOW-1:0] * crab2[i][LOW-1:0];
      end

      ssq4 <= ssq3;
      for (int i = 0; i < 3; i++) begin
        csq4[i] <= (CSQW'(hh3[i]) << (2 * LOW)) + (CSQW'(hl3[i]) << (LOW + 1))
                   + CSQW'(ll3[i]);
      end

      ssq5 <= ssq4;
      csq5 <= RADW'(csq4[0]) + RADW'(csq4[1]) + RADW'(csq4[2]);
    end
  end

  cbe_isqrt u_cross_root (
    .clk      (clk),
    .en       (en),
    .radicand (csq5),
    .root     (m_root)
  );

  cbe_isqrt u_speed_root (
    .clk      (clk),
    .en       (en),
    .radicand (RADW'(ssq5)),
    .root     (s_root)
  );

  assign s_val = s_root[SW-1:0];

  // Speed floor test and speed cubed.
  always_ff @(posedge clk) begin
    if (en) begin
      s2_1  <= s_val * s_val;
      s1    <= s_val;
      m1    <= m_root;
      slow1 <= (s_root <= ROOT_BITS'(speed_floor));

      phi2  <= s2_1[2*SW-1:SW] * s1;
      plo2  <= s2_1[SW-1:0] * s1;
      m2    <= m1;
      slow2 <= slow1;

      den3  <= (DENW'(phi2) << SW) + DENW'(plo2);
      m3    <= m2;
      slow3 <= slow2;
    end
  end

  cbe_div u_div (
    .clk        (clk),
    .en         (en),
    .cross_mag  (m3),
    .speed_cube (den3),
    .slow_in    (slow3),
    .curvature  (curvature),
    .slow_flag  (slow_flag)
  );

endmodule
`default_nettype wire

[src/cubic_bezier_evaluator.sv]
`default_nettype none
// Channel   Direction  Signals                           Content
// s_        in         s_tvalid s_tready s_tdata[23:0]   param_t
// m_        out        m_tvalid m_tready m_tdata[239:0]  point, derivatives, curvature
//                      m_tuser[0:0]                      slow_flag
// cfg_      in         cfg_write cfg_index cfg_data      control points, speed floor
//
// One sample enters per cycle while the skid entry is free.
// The depth comes mostly from the two square roots (51 stages, one root bit each)
// and the 25 stage curvature divide behind the Horner stages.
// rst is synchronous: control points clear to zero, speed floor to one.
// A two-entry output register absorbs a stall; s_tready follows its fill level.
module cubic_bezier_evaluator (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [cbe_pkg::IDXW-1:0]   cfg_index,
  input  logic [cbe_pkg::CFGW-1:0]   cfg_data,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [cbe_pkg::IN_DW-1:0]  s_tdata,   // param_t
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [cbe_pkg::OUT_DW-1:0] m_tdata,   // pos_x pos_y pos_z tan_x tan_y tan_z
                                                // acc_x acc_y acc_z curvature
  output logic [0:0]                 m_tuser    // slow_flag
);
  import cbe_pkg::*;

  logic [CFGW-1:0] start_point, first_handle, second_handle, end_point;
  logic [SFW-1:0]  speed_floor;

  logic                 en;
  logic [TOTAL_LAT-1:0] vld;
  pay_t                 poly_pay;
  pay_t                 dly [CURV_LAT];
  logic [CURW-1:0]      curvature;
  logic                 slow_flag;
  res_t                 pipe_res;
  res_t                 out_res, skid_res;
  logic                 out_valid, skid_valid;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      start_point   <= '0;
      first_handle  <= '0;
      second_handle <= '0;
      end_point     <= '0;
      speed_floor   <= SFW'(1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_START_POINT:   start_point   <= cfg_data;
        REG_FIRST_HANDLE:  first_handle  <= cfg_data;
        REG_SECOND_HANDLE: second_handle <= cfg_data;
        REG_END_POINT:     end_point     <= cfg_data;
        REG_SPEED_FLOOR:   speed_floor   <= cfg_data[SFW-1:0];
        default: begin
        end
      endcase
    end
  end

  // The whole pipeline moves while the skid entry is free.
  assign en       = !skid_valid;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[TOTAL_LAT-2:0], s_tvalid};
    end
  end

  cbe_poly u_poly (
    .clk           (clk),
    .en            (en),
    .start_point   (start_point),
    .first_handle  (first_handle),
    .second_handle (second_handle),
    .end_point     (end_point),
    .param_t       (s_tdata[TW-1:0]),
    .pay           (poly_pay)
  );

  cbe_curv u_curv (
    .clk         (clk),
    .en          (en),
    .speed_floor (speed_floor),
    .pay         (poly_pay),
    .curvature   (curvature),
    .slow_flag   (slow_flag)
  );

  // Point and derivatives wait for the curvature.
  always_ff @(posedge clk) begin
    if (en) begin
      dly[0] <= poly_pay;
      for (int i = 1; i < CURV_LAT; i++) begin
        dly[i] <= dly[i-1];
      end
    end
  end

  assign pipe_res.slow = slow_flag;
  assign pipe_res.curv = curvature;
  assign pipe_res.pay  = dly[CURV_LAT-1];

  // Output register and skid entry: control.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (m_tready) begin
        skid_valid <= 1'b0;
      end
    end else if (vld[TOTAL_LAT-1]) begin
      if (out_valid && !m_tready) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register and skid entry: data.
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (m_tready) begin
        out_res <= skid_res;
      end
    end else if (vld[TOTAL_LAT-1]) begin
      if (out_valid && !m_tready) begin
        skid_res <= pipe_res;
      end else begin
        out_res <= pipe_res;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{PADW{1'b0}}, out_res.curv, out_res.pay};
  assign m_tuser  = out_res.slow;

  a_skid_behind_out : assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry holds a result while the output register is empty");

  a_stall_holds : assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("pipeline valid bits moved during a stall");

  a_skid_refill : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && skid_valid) |=> m_tvalid)
    else $error("result in the skid entry was lost after an output transfer");

  a_slow_zero : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (out_res.curv == '0))
    else $error("slow curve reported a nonzero curvature");

endmodule
`default_nettype wire
